// ===== sv/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared codes, constants and control types for the bounded stack block.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned DIV_W  = 16;   // count * 100 stays below 2**16
  localparam int unsigned DIV_STEPS_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam logic [DIV_W-1:0] PCT_SCALE = 16'd100;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [DIV_STEPS_W-1:0] DIV_STEPS = 3'd7;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_POP  = 3'd1;
  localparam logic [OP_W-1:0] OP_TOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_GET  = 3'd3;
  localparam logic [OP_W-1:0] OP_MIN  = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TOP_EMPTY = 3'd2;
  localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 3'd3;
  localparam logic [ERR_W-1:0] ERR_GET_EMPTY = 3'd4;
  localparam logic [ERR_W-1:0] ERR_GET_RANGE = 3'd5;
  localparam logic [ERR_W-1:0] ERR_MIN_EMPTY = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic load;     // set up divider and scan
    logic run;      // advance divider and scan
  } bsm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_busy;
    logic div_busy;
  } bsm_status_t;

endpackage

// ===== sv/bsm_datapath.sv =====
// ----------------------------------------------------------------------------
// bsm_datapath
// Stack memory, pointer, capacity register, min scan and percentage divider.
// ----------------------------------------------------------------------------
module bsm_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsm_pkg::bsm_cmd_t             cmd_i,
  output bsm_pkg::bsm_status_t          status_o,
  input  logic [bsm_pkg::OP_W-1:0]      op_i,
  input  logic signed [31:0]            value_i,
  input  logic [7:0]                    index_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsm_pkg::CAP_W-1:0]     cfg_data_i,
  output logic signed [31:0]            read_value_o,
  output logic [7:0]                    min_position_o,
  output logic [8:0]                    entry_count_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic [bsm_pkg::PCT_W-1:0]     percent_used_o,
  output logic [bsm_pkg::ERR_W-1:0]     error_code_o
);
  import bsm_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW = (PW > CAP_W) ? PW : CAP_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [DATA_WIDTH-1:0] stack_mem [DEPTH];

  logic [PW-1:0]          ptr_q, ptr_d;
  logic [CAP_W-1:0]       cap_q;
  logic [OP_W-1:0]        op_q;
  logic [ERR_W-1:0]       err_q, err_d;
  logic [DATA_WIDTH-1:0]  rdata_q;
  logic [DATA_WIDTH-1:0]  rd_q;
  logic                   scan_active_q;
  logic                   first_q;
  logic [PW-1:0]          next_addr_q;
  logic [AW-1:0]          rd_pos_q;
  logic [DATA_WIDTH-1:0]  best_q;
  logic [AW-1:0]          minpos_q;
  logic [DIV_W-1:0]       rem_q;
  logic [DIV_W-1:0]       dv_q;
  logic [PCT_W-1:0]       quo_q;
  logic [DIV_STEPS_W-1:0] dcnt_q;
  logic                   sat_q;

  logic                   wr_en, rd_en;
  logic [AW-1:0]          raddr;
  logic [DATA_WIDTH-1:0]  wdata;
  logic [XW-1:0]          cap_x, ptr_x;
  logic [CAP_W-1:0]       cap_eff;
  logic                   scan_start, next_more, take_new;
  logic [DIV_W-1:0]       rem_load;

  // effective capacity: zero counts as one, clipped to DEPTH
  always_comb begin
    cap_x = XW'(cap_q);
    if (cap_q == '0) begin
      cap_x = XW'(1);
    end
    if (cap_x > DEPTH_X) begin
      cap_x = DEPTH_X;
    end
    cap_eff = CAP_W'(cap_x);
  end

  assign ptr_x      = XW'(ptr_q);
  assign wdata      = DATA_WIDTH'(64'(value_i));
  assign scan_start = (op_q == OP_MIN) && (err_q == ERR_NONE);
  assign next_more  = next_addr_q < ptr_q;
  assign take_new   = first_q || ($signed(rdata_q) < $signed(best_q));
  assign rem_load   = DIV_W'(ptr_x[CAP_W-1:0]) * PCT_SCALE;

  // request decode and memory port control
  always_comb begin
    err_d = ERR_NONE;
    ptr_d = ptr_q;
    wr_en = 1'b0;
    rd_en = 1'b0;
    raddr = '0;
    if (cmd_i.accept) begin
      unique case (op_i)
        OP_PUSH: begin
          if (ptr_x >= cap_x) begin
            err_d = ERR_PUSH_FULL;
          end else begin
            wr_en = 1'b1;
            ptr_d = ptr_q + PW'(1);
          end
        end
        OP_POP: begin
          if (ptr_q == '0) begin
            err_d = ERR_POP_EMPTY;
          end else begin
            ptr_d = ptr_q - PW'(1);
          end
        end
        OP_TOP: begin
          if (ptr_q == '0) begin
            err_d = ERR_TOP_EMPTY;
          end else begin
            rd_en = 1'b1;
            raddr = AW'(ptr_q - PW'(1));
          end
        end
        OP_GET: begin
          if (ptr_q == '0) begin
            err_d = ERR_GET_EMPTY;
          end else if (XW'(index_i) >= ptr_x) begin
            err_d = ERR_GET_RANGE;
          end else begin
            rd_en = 1'b1;
            raddr = AW'(index_i);
          end
        end
        OP_MIN: begin
          if (ptr_q == '0) begin
            err_d = ERR_MIN_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.load && scan_start) begin
      rd_en = 1'b1;
      raddr = '0;
    end else if (cmd_i.run && scan_active_q && next_more) begin
      rd_en = 1'b1;
      raddr = AW'(next_addr_q);
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[AW'(ptr_q)] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= stack_mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      cap_q         <= CAP_RESET;
      scan_active_q <= 1'b0;
      dcnt_q        <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        scan_active_q <= scan_start;
        dcnt_q        <= DIV_STEPS;
      end else if (cmd_i.run) begin
        if (scan_active_q && !next_more) begin
          scan_active_q <= 1'b0;
        end
        if (dcnt_q != '0) begin
          dcnt_q <= dcnt_q - DIV_STEPS_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      err_q <= err_d;
    end
    if (cmd_i.load) begin
      if (err_q == ERR_NONE && (op_q == OP_TOP || op_q == OP_GET)) begin
        rd_q <= rdata_q;
      end else begin
        rd_q <= '0;
      end
      first_q     <= 1'b1;
      rd_pos_q    <= '0;
      next_addr_q <= PW'(1);
      minpos_q    <= '0;
      sat_q       <= ptr_x >= cap_x;
      rem_q       <= rem_load;
      dv_q        <= DIV_W'(cap_eff) << (PCT_W - 1);
      quo_q       <= '0;
    end else if (cmd_i.run) begin
      if (scan_active_q) begin
        first_q <= 1'b0;
        if (take_new) begin
          best_q   <= rdata_q;
          minpos_q <= rd_pos_q;
        end
        if (next_more) begin
          rd_pos_q    <= AW'(next_addr_q);
          next_addr_q <= next_addr_q + PW'(1);
        end
      end
      // restoring division, one quotient bit per step
      if (dcnt_q != '0) begin
        if (rem_q >= dv_q) begin
          rem_q <= rem_q - dv_q;
          quo_q <= {quo_q[PCT_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[PCT_W-2:0], 1'b0};
        end
        dv_q <= dv_q >> 1;
      end
    end
  end

  assign status_o.scan_busy = scan_active_q;
  assign status_o.div_busy  = dcnt_q != '0;
  assign cfg_ready_o        = 1'b1;

  assign read_value_o   = 32'(rd_q);
  assign min_position_o = scan_start ? 8'(minpos_q) : 8'd0;
  assign entry_count_o  = 9'(ptr_x);
  assign is_empty_o     = ptr_q == '0;
  assign is_full_o      = ptr_x >= cap_x;
  assign percent_used_o = sat_q ? PCT_FULL : quo_q;
  assign error_code_o   = err_q;

endmodule

// ===== sv/bsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsm_ctrl
// Request sequencer: accept, set up, run until scan and divide finish, report.
// ----------------------------------------------------------------------------
module bsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 result_valid_o,
  output bsm_pkg::bsm_cmd_t    cmd_o,
  input  bsm_pkg::bsm_status_t status_i
);
  import bsm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (!status_i.scan_busy && !status_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = state_q == S_OUT;

endmodule

// ===== sv/bounded_stack_with_min_search.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_min_search
// Bounded LIFO of signed words with top, get-at-index and min-index search.
// ----------------------------------------------------------------------------
//
// Channel   Signals                               Handshake
// -------   -----------------------------------   ------------------------------
// request   op_i value_i index_i                  start high while busy low
// result    read_value_o .. error_code_o          result_valid_o, one cycle only
// config    cfg_data_i (capacity)                 cfg_valid_i && cfg_ready_o
//
// One request in flight at a time. After the accept the block passes through
// a setup state, then a run state until the min scan (min search only) and
// the percentage divider are both done, then the result state. The 7-step
// divider and the one-entry-per-cycle walk over the single memory read port
// set the length of the run. Reset clears the pointer and sets capacity to
// 256; stack memory is not cleared. The receiver cannot stall: the result is
// shown for exactly one cycle and busy drops the cycle after.
//
module bounded_stack_with_min_search #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic [bsm_pkg::OP_W-1:0]  op_i,
  input  logic signed [31:0]        value_i,
  input  logic [7:0]                index_i,
  // config
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bsm_pkg::CAP_W-1:0] cfg_data_i,
  // result
  output logic                      result_valid_o,
  output logic signed [31:0]        read_value_o,
  output logic [7:0]                min_position_o,
  output logic [8:0]                entry_count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o,
  output logic [bsm_pkg::PCT_W-1:0] percent_used_o,
  output logic [bsm_pkg::ERR_W-1:0] error_code_o
);
  import bsm_pkg::*;

  bsm_cmd_t    cmd;     // sequencing commands
  bsm_status_t status;  // scan / divider activity

  bsm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  bsm_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .value_i        (value_i),
    .index_i        (index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .read_value_o   (read_value_o),
    .min_position_o (min_position_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .percent_used_o (percent_used_o),
    .error_code_o   (error_code_o)
  );

  // an accepted request always makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // the divider and scan never run outside a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.run || cmd.load) |-> busy)
    else $error("datapath running while idle");

  // a failed request never reports a read value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && error_code_o != ERR_NONE) |-> (read_value_o == '0))
    else $error("read value on failed request");

  // full stack always reports full usage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_full_o) |-> (percent_used_o == PCT_FULL))
    else $error("full stack with usage below 100");

endmodule

// ===== bench/bounded_stack_with_min_search_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_min_search_tb
// Self-checking bench for the bounded stack: a shadow stack predicts each
// result, directed cases hit the error codes and capacity corners, then
// random phases with push-biased and pop-biased mixes sweep the depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_stack_with_min_search_tb;
  import bsm_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned CYCLE_CAP  = 2_000_000;  // well above the worst-case run length
  localparam int unsigned DRAIN_WAIT = 300;        // longer than a full min scan
  localparam int unsigned MAX_REPORT = 10;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_NOP_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_NOP_LAST  = 3'd7;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         min_position;
    logic [8:0]         entry_count;
    logic               is_empty;
    logic               is_full;
    logic [PCT_W-1:0]   percent_used;
    logic [ERR_W-1:0]   error_code;
  } stack_result_t;

  // DUT ports; the inputs are all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     op_i        = OP_PUSH;
  logic signed [31:0]  value_i     = '0;
  logic [7:0]          index_i     = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i  = '0;
  logic                result_valid_o;
  logic signed [31:0]  read_value_o;
  logic [7:0]          min_position_o;
  logic [8:0]          entry_count_o;
  logic                is_empty_o;
  logic                is_full_o;
  logic [PCT_W-1:0]    percent_used_o;
  logic [ERR_W-1:0]    error_code_o;

  // shadow copy of the stack and its capacity register
  logic signed [31:0]  shadow_words [DEPTH];
  int unsigned         shadow_count    = 0;
  logic [CAP_W-1:0]    shadow_capacity = CAP_RESET;

  stack_result_t       pending_results [$];

  int unsigned         gap_pct        = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         request_count  = 0;
  int unsigned         error_results  = 0;
  int unsigned         min_searches   = 0;
  int unsigned         cap_writes     = 0;
  int unsigned         deepest        = 0;

  bounded_stack_with_min_search i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .index_i        (index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .min_position_o (min_position_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .percent_used_o (percent_used_o),
    .error_code_o   (error_code_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("bounded_stack_with_min_search_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow stack: applies one op and returns the status the block must report.
  // Capacity 0 acts as 1, anything above DEPTH acts as DEPTH. Failed ops leave
  // the stack alone. Min search is a signed compare; strict less-than keeps the
  // lowest index on ties.
  // --------------------------------------------------------------------------
  function automatic stack_result_t predict_stack_op(input logic [OP_W-1:0] op,
                                                     input logic signed [31:0] word,
                                                     input logic [7:0] idx);
    stack_result_t r;
    int unsigned   lim;
    int unsigned   pct;
    r   = '0;
    lim = (shadow_capacity == 0) ? 1 :
          (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
    case (op)
      OP_PUSH: begin
        if (shadow_count >= lim) begin
          r.error_code = ERR_PUSH_FULL;
        end else begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) r.error_code = ERR_POP_EMPTY;
        else shadow_count--;
      end
      OP_TOP: begin
        if (shadow_count == 0) r.error_code = ERR_TOP_EMPTY;
        else r.read_value = shadow_words[shadow_count-1];
      end
      OP_GET: begin
        if (shadow_count == 0) r.error_code = ERR_GET_EMPTY;
        else if (idx >= shadow_count) r.error_code = ERR_GET_RANGE;
        else r.read_value = shadow_words[idx];
      end
      OP_MIN: begin
        if (shadow_count == 0) begin
          r.error_code = ERR_MIN_EMPTY;
        end else begin
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_words[i] < shadow_words[r.min_position]) r.min_position = 8'(i);
          end
        end
      end
      default: ;  // unused codes only report status
    endcase
    pct = (shadow_count * 100) / lim;
    if (pct > 100) pct = 100;
    r.entry_count  = 9'(shadow_count);
    r.is_empty     = (shadow_count == 0);
    r.is_full      = (shadow_count >= lim);
    r.percent_used = PCT_W'(pct);
    return r;
  endfunction

  function automatic string result_text(input stack_result_t r);
    return $sformatf("rd=%0d min=%0d cnt=%0d empty=%0b full=%0b pct=%0d err=%0d",
                     r.read_value, r.min_position, r.entry_count, r.is_empty,
                     r.is_full, r.percent_used, r.error_code);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every strobed result is matched against the oldest
  // prediction. Outputs are read right after the edge, before the DUT's
  // nonblocking updates land, so they hold the values of the cycle that ended.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && result_valid_o) begin
      got = {read_value_o, min_position_o, entry_count_o, is_empty_o, is_full_o,
             percent_used_o, error_code_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
          $display("%0t: result with no request pending: %s", $realtime,
                   result_text(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", result_text(want));
            $display("  actual   %s", result_text(got));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. start stays high after an accept; the next call either
  // replaces the request in the same step or drops start for an idle gap, so
  // start never sees two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [31:0] word,
                              input logic [7:0] idx);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= word;
    index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    pending_results.push_back(predict_stack_op(op, word, idx));
    request_count++;
    if (pending_results[$].error_code != ERR_NONE) error_results++;
    if (op == OP_MIN) min_searches++;
    if (shadow_count > deepest) deepest = shadow_count;
  endtask

  // capacity only changes while no request is in flight
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    shadow_capacity  = cap;
    cap_writes++;
  endtask

  // mix of full-range words, the extremes and a narrow band that forces ties
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(3))
      0: return $urandom_range(9) - 5;
      1: begin
        case ($urandom_range(3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly live positions, sometimes anywhere in the 8-bit range
  function automatic logic [7:0] random_index();
    if (shadow_count != 0 && $urandom_range(3) != 0)
      return 8'($urandom_range(shadow_count - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [OP_W-1:0] random_op(input int unsigned push_weight);
    int unsigned r;
    if ($urandom_range(99) < push_weight) return OP_PUSH;
    r = $urandom_range(19);
    if (r < 7)  return OP_POP;
    if (r < 10) return OP_TOP;
    if (r < 15) return OP_GET;
    if (r < 18) return OP_MIN;
    return OP_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
  endfunction

  function automatic logic [CAP_W-1:0] random_capacity();
    case ($urandom_range(7))
      0: return '0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd256;
      4: return 9'd511;
      5: return CAP_W'($urandom_range(257, 510));
      default: return CAP_W'($urandom_range(3, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // every op but push on an empty stack, the unused codes included
  task automatic test_empty_stack();
    send_request(OP_POP, random_word(), 8'd0);
    send_request(OP_TOP, random_word(), 8'd0);
    send_request(OP_GET, random_word(), 8'd0);
    send_request(OP_MIN, random_word(), 8'd0);
    for (int op = OP_NOP_FIRST; op <= OP_NOP_LAST; op++)
      send_request(OP_W'(op), random_word(), 8'hff);
  endtask

  // word extremes, a tie on the minimum, index in and out of range
  task automatic test_push_and_reads();
    send_request(OP_PUSH, WORD_MAX, 8'd0);
    send_request(OP_PUSH, WORD_MIN, 8'd0);
    send_request(OP_PUSH, '0, 8'd0);
    send_request(OP_PUSH, -1, 8'd0);
    send_request(OP_PUSH, WORD_MIN, 8'd0);   // same minimum again, lower index wins
    send_request(OP_TOP, '0, 8'd0);
    send_request(OP_GET, '0, 8'd0);
    send_request(OP_GET, '0, 8'd4);
    send_request(OP_GET, '0, 8'd5);          // one past the top
    send_request(OP_GET, '0, 8'd255);
    send_request(OP_MIN, '0, 8'd0);
    send_request(OP_POP, '0, 8'd0);
    send_request(OP_MIN, '0, 8'd0);
    send_request(OP_TOP, '0, 8'd0);
  endtask

  // capacity zero, capacity below count, capacity above depth
  task automatic test_capacity_corners();
    write_capacity('0);
    send_request(OP_PUSH, 32'sd7, 8'd0);     // count over capacity: full, pct saturates
    send_request(OP_POP, '0, 8'd0);
    write_capacity(9'd511);
    send_request(OP_PUSH, 32'sd9, 8'd0);
    write_capacity(9'd4);
    send_request(OP_PUSH, 32'sd11, 8'd0);    // exactly full
  endtask

  // fill all 256 entries, read the last, search the lot, then unwind
  task automatic test_deep_fill();
    write_capacity(9'd256);
    while (shadow_count < DEPTH) begin
      if ($urandom_range(9) == 0) send_request(OP_TOP, random_word(), random_index());
      else send_request(OP_PUSH, random_word(), random_index());
    end
    send_request(OP_PUSH, random_word(), 8'd0);
    send_request(OP_GET, random_word(), 8'd255);
    send_request(OP_MIN, random_word(), 8'd0);
    write_capacity(9'd511);
    send_request(OP_PUSH, random_word(), 8'd0);
    while (shadow_count != 0) begin
      case ($urandom_range(9))
        0: send_request(OP_GET, random_word(), random_index());
        1: send_request(OP_MIN, random_word(), random_index());
        default: send_request(OP_POP, random_word(), random_index());
      endcase
    end
    send_request(OP_POP, random_word(), 8'd0);
  endtask

  // chunks of random requests, each with its own capacity and push bias
  task automatic test_random_mix(input int unsigned gap, input int unsigned chunks);
    int unsigned push_weight;
    gap_pct = gap;
    repeat (chunks) begin
      write_capacity(random_capacity());
      push_weight = $urandom_range(15, 85);
      repeat (32) send_request(random_op(push_weight), random_word(), random_index());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 18;
    test_empty_stack();
    test_push_and_reads();
    test_capacity_corners();
    test_deep_fill();
    test_random_mix(18, 12);
    test_random_mix(56, 12);
    test_random_mix(0, 12);

    // drain, then watch for stray results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("ran %0d requests: %0d min searches, %0d error results, stack depth up to %0d",
             request_count, min_searches, error_results, deepest);
    $display("capacity written %0d times; %0d mismatches, %0d results never seen",
             cap_writes, mismatch_count, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bounded_stack_with_min_search_tb OK");
    end else begin
      $display("bounded_stack_with_min_search_tb NOT OK");
    end
    $finish;
  end

endmodule
